>>> hdl/prk_pkg.sv
// Package for the permutation rank block: widths, limits and the item that
// passes from the classifying front end to the accumulating back end.
// Depends on nothing; every other file refers to it by scoped names.
package prk_pkg;

  localparam int MAX_LEN = 20;
  localparam int LEN_W   = 5;
  localparam int RANK_W  = 62;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(MAX_LEN);
  localparam logic [MAX_LEN-1:0] MASK_FULL = '1;

  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic [LEN_W-1:0] weight;
    logic             last;
    logic             err;
  } item_t;

endpackage

>>> hdl/prk_front.sv
// Front end of the permutation rank block: checks each element against the
// mask of unseen values and turns it into a count and a Horner weight.
// Depends on prk_pkg.
module prk_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [prk_pkg::LEN_W-1:0]  cfg_len,
  input  logic                       take,
  input  logic [prk_pkg::LEN_W-1:0]  element,
  output prk_pkg::item_t             item
);

  logic [prk_pkg::LEN_W-1:0]   eff_len;
  logic [prk_pkg::MAX_LEN-1:0] unseen;
  logic [prk_pkg::LEN_W-1:0]   position;
  logic                        error_seen;

  logic [prk_pkg::MAX_LEN-1:0] sel;
  logic [prk_pkg::MAX_LEN-1:0] below;
  logic [prk_pkg::LEN_W-1:0]   cnt;
  logic                        ok;
  logic                        last;
  logic [prk_pkg::LEN_W-1:0]   len_clamped;

  always_comb begin
    for (int i = 0; i < prk_pkg::MAX_LEN; i++) begin
      sel[i]   = (element == prk_pkg::LEN_W'(i + 1));
      below[i] = (prk_pkg::LEN_W'(i + 1) < element);
    end
    cnt = '0;
    for (int i = 0; i < prk_pkg::MAX_LEN; i++) begin
      cnt = cnt + prk_pkg::LEN_W'(unseen[i] & below[i]);
    end
    ok   = (element != '0) && (element <= eff_len) && ((unseen & sel) != '0);
    last = (position == eff_len - prk_pkg::LEN_W'(1));
    item.count  = ok ? cnt : '0;
    item.weight = eff_len - position;
    item.last   = last;
    item.err    = error_seen | ~ok;
  end

  always_comb begin
    if (cfg_len == '0) begin
      len_clamped = prk_pkg::LEN_W'(1);
    end else if (cfg_len > prk_pkg::LEN_RESET) begin
      len_clamped = prk_pkg::LEN_RESET;
    end else begin
      len_clamped = cfg_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len    <= prk_pkg::LEN_RESET;
      unseen     <= prk_pkg::MASK_FULL;
      position   <= '0;
      error_seen <= 1'b0;
    end else if (cfg_write) begin
      eff_len    <= len_clamped;
      unseen     <= prk_pkg::MASK_FULL;
      position   <= '0;
      error_seen <= 1'b0;
    end else if (take) begin
      if (last) begin
        unseen     <= prk_pkg::MASK_FULL;
        position   <= '0;
        error_seen <= 1'b0;
      end else begin
        unseen     <= ok ? (unseen & ~sel) : unseen;
        position   <= position + prk_pkg::LEN_W'(1);
        error_seen <= error_seen | ~ok;
      end
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    position < eff_len)
    else $error("position has run past the permutation length");

endmodule

>>> hdl/prk_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on prk_pkg.
module prk_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  prk_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output prk_pkg::item_t head_item
);

  prk_pkg::item_t               slots [prk_pkg::QDEPTH];
  logic [prk_pkg::QPTR_W-1:0]   wr_ptr;
  logic [prk_pkg::QPTR_W-1:0]   rd_ptr;
  logic [prk_pkg::QCNT_W-1:0]   fill;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (fill == prk_pkg::QCNT_W'(prk_pkg::QDEPTH));
  assign not_empty = (fill != '0);
  assign head_item = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + prk_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + prk_pkg::QPTR_W'(1);
      end
      fill <= fill + prk_pkg::QCNT_W'(do_push) - prk_pkg::QCNT_W'(do_pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= prk_pkg::QCNT_W'(prk_pkg::QDEPTH))
    else $error("queue fill level exceeds its depth");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + prk_pkg::QCNT_W'(1)))
    else $error("queue fill level did not follow a request");

endmodule

>>> hdl/prk_back.sv
// Back end of the permutation rank block: Horner accumulation of the rank
// and the output register that holds a finished result.
// Depends on prk_pkg.
module prk_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        have_item,
  input  prk_pkg::item_t              item,
  output logic                        take_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [prk_pkg::RANK_W-1:0]  rank,
  output logic                        invalid
);

  logic [prk_pkg::RANK_W-1:0] acc;
  logic [prk_pkg::RANK_W-1:0] acc_next;
  logic [prk_pkg::RANK_W+prk_pkg::LEN_W-1:0] prod;

  assign take_item = have_item && (!item.last || !out_valid || out_ready);

  always_comb begin
    prod     = {{prk_pkg::LEN_W{1'b0}}, acc}
             * {{prk_pkg::RANK_W{1'b0}}, item.weight};
    acc_next = prod[prk_pkg::RANK_W-1:0] + prk_pkg::RANK_W'(item.count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        acc <= '0;
      end else if (take_item) begin
        acc <= item.last ? '0 : acc_next;
      end
      if (take_item && item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_item && item.last) begin
      rank    <= item.err ? '0 : acc_next;
      invalid <= item.err;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(rank) && $stable(invalid)))
    else $error("a waiting result was overwritten");

endmodule

>>> hdl/permutation_rank.sv
// Top level of the permutation rank block: lexicographic rank of a
// permutation given one element per request. Uses prk_pkg, prk_front,
// prk_queue and prk_back.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_valid / cfg_ready   perm_length
//   in       in         in_valid / in_ready     element
//   out      out        out_valid / out_ready   rank, invalid
//
// One element is taken every cycle while the four-entry queue has room and
// no length write waits. The back end applies one 62 by 5 bit multiply-add
// per cycle unless stalled; a result is registered as its last item leaves
// the queue. Reset restores a length of 20 and clears all progress.
// A stalled output only holds up the back end at a permutation's last
// element; the queue then absorbs up to three further elements.
// A length write waits until the queue is empty and holds off the input.
module permutation_rank (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [prk_pkg::LEN_W-1:0]   perm_length,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prk_pkg::LEN_W-1:0]   element,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [prk_pkg::RANK_W-1:0]  rank,
  output logic                        invalid
);

  prk_pkg::item_t front_item;
  prk_pkg::item_t head_item;
  logic           q_full;
  logic           q_not_empty;
  logic           back_take;
  logic           cfg_write;
  logic           in_take;

  assign cfg_ready = !q_not_empty;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = !q_full && !cfg_valid;
  assign in_take   = in_valid && in_ready;

  prk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_len   (perm_length),
    .take      (in_take),
    .element   (element),
    .item      (front_item)
  );

  prk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_take),
    .push_item (front_item),
    .full      (q_full),
    .pop       (back_take),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  prk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .have_item (q_not_empty),
    .item      (head_item),
    .take_item (back_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rank      (rank),
    .invalid   (invalid)
  );

endmodule

>>> tb/sv/permutation_rank_tb.sv
// Self-checking testbench for permutation_rank: directed and random permutations,
// checked field by field against a predicted rank for every completed request sequence.
// Depends on prk_pkg and permutation_rank only.
module permutation_rank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    logic [prk_pkg::RANK_W-1:0] rank;
    logic                       invalid;
  } rank_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [prk_pkg::LEN_W-1:0]  perm_length = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [prk_pkg::LEN_W-1:0]  element = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [prk_pkg::RANK_W-1:0] rank;
  logic                       invalid;

  logic [prk_pkg::LEN_W-1:0]   length_reg = prk_pkg::LEN_RESET;
  logic [prk_pkg::MAX_LEN-1:0] unseen = prk_pkg::MASK_FULL;
  int unsigned                 taken = 0;
  logic [prk_pkg::RANK_W-1:0]  partial_rank = '0;
  logic                        bad_seen = 1'b0;
  rank_result_t                expected_ranks[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  permutation_rank u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .perm_length (perm_length),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .element     (element),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rank        (rank),
    .invalid     (invalid)
  );

  always #6 clk = ~clk;

  function automatic int clamp_len(logic [prk_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > prk_pkg::MAX_LEN) return prk_pkg::MAX_LEN;
    return int'(v);
  endfunction

  function automatic void clear_progress();
    unseen = prk_pkg::MASK_FULL;
    taken = 0;
    partial_rank = '0;
    bad_seen = 1'b0;
  endfunction

  function automatic void advance_rank(logic [prk_pkg::LEN_W-1:0] e);
    int unsigned                 n;
    int unsigned                 smaller;
    logic [prk_pkg::MAX_LEN-1:0] one_hot;
    rank_result_t                r;
    n = clamp_len(length_reg);
    smaller = 0;
    if (e >= 1 && e <= n && unseen[e-1]) begin
      one_hot = '0;
      one_hot[e-1] = 1'b1;
      smaller = $countones(unseen & (one_hot - 1'b1));
      unseen = unseen & ~one_hot;
    end else begin
      bad_seen = 1'b1;
    end
    partial_rank = partial_rank * prk_pkg::RANK_W'(n - taken) + prk_pkg::RANK_W'(smaller);
    taken++;
    if (taken >= n) begin
      r.rank = bad_seen ? '0 : partial_rank;
      r.invalid = bad_seen;
      expected_ranks.push_back(r);
      clear_progress();
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", what);
  endfunction

  always @(posedge clk) begin : check_results
    rank_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_ranks.size() == 0) begin
        note_mismatch($sformatf("unexpected result: rank %0d invalid %0b", rank, invalid));
      end else begin
        want = expected_ranks.pop_front();
        if (rank !== want.rank)
          note_mismatch($sformatf("rank: expected %0d, got %0d", want.rank, rank));
        if (invalid !== want.invalid)
          note_mismatch($sformatf("invalid: expected %0b, got %0b", want.invalid, invalid));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_element(logic [prk_pkg::LEN_W-1:0] e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    element = e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_rank(e);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_ranks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(logic [prk_pkg::LEN_W-1:0] len);
    wait_idle();
    cfg_valid = 1'b1;
    perm_length = len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    length_reg = len;
    clear_progress();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_shuffled(int n, int corrupt_pct);
    logic [prk_pkg::LEN_W-1:0] p[prk_pkg::MAX_LEN];
    logic [prk_pkg::LEN_W-1:0] t;
    int                        j;
    for (int i = 0; i < n; i++) p[i] = prk_pkg::LEN_W'(i + 1);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    if ($urandom_range(99) < corrupt_pct)
      p[$urandom_range(n - 1)] = prk_pkg::LEN_W'($urandom_range(31));
    for (int i = 0; i < n; i++) send_element(p[i]);
  endtask

  // The reversed permutation at the reset length gives the largest rank.
  task automatic test_longest_reverse();
    for (int v = prk_pkg::MAX_LEN; v >= 1; v--) send_element(prk_pkg::LEN_W'(v));
  endtask

  task automatic test_length_one();
    set_length(5'd1);
    send_element(5'd1);
    send_element(5'd0);
    send_element(5'd31);
    set_length(5'd0);
    send_element(5'd1);
    send_element(5'd2);
  endtask

  task automatic test_bad_elements();
    set_length(5'd3);
    send_element(5'd3);
    send_element(5'd1);
    send_element(5'd2);
    send_element(5'd2);
    send_element(5'd2);
    send_element(5'd1);
    send_element(5'd4);
    send_element(5'd1);
    send_element(5'd2);
  endtask

  // A length write part-way through a permutation starts a fresh one.
  task automatic test_mid_permutation_write();
    set_length(5'd4);
    send_element(5'd4);
    send_element(5'd3);
    set_length(5'd2);
    send_element(5'd2);
    send_element(5'd1);
  endtask

  // The receiver holds off while requests keep coming, so the input must stall.
  task automatic test_output_hold_off();
    set_length(5'd2);
    hold_left = HOLD_OFF_CYCLES;
    repeat (8) send_shuffled(2, 0);
  endtask

  task automatic test_random_phase(logic [prk_pkg::LEN_W-1:0] len, int idle, int stall,
                                   int count);
    int n;
    int k;
    int sent;
    idle_pct = idle;
    stall_pct = stall;
    set_length(len);
    n = clamp_len(len);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 10) begin
        k = $urandom_range(n, 1);
        repeat (k) send_element(prk_pkg::LEN_W'($urandom_range(31)));
        sent += k;
      end else begin
        send_shuffled(n, 15);
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_longest_reverse();
    test_length_one();
    test_bad_elements();
    test_mid_permutation_write();
    test_output_hold_off();

    test_random_phase(5'd4, 0, 0, 100);
    test_random_phase(5'd20, 0, 0, 100);
    test_random_phase(5'd7, 50, 0, 100);
    test_random_phase(5'd31, 50, 0, 80);
    test_random_phase(5'd2, 0, 50, 100);
    test_random_phase(5'd12, 0, 50, 100);
    test_random_phase(5'd1, 9, 9, 40);
    test_random_phase(5'd0, 9, 9, 20);
    test_random_phase(5'd5, 9, 9, 100);
    test_random_phase(5'd21, 9, 9, 60);
    test_random_phase(5'd3, 0, 0, 60);

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> permutation_rank.f
hdl/prk_pkg.sv
hdl/prk_front.sv
hdl/prk_queue.sv
hdl/prk_back.sv
hdl/permutation_rank.sv
tb/sv/permutation_rank_tb.sv
